### sv/cec_pkg.sv
// Shared types, constants and microcode program for the calendar epoch converter.
`default_nettype none
package cec_pkg;

	localparam int PC_W = 5;

	localparam logic [31:0] SECS_PER_DAY   = 32'd86400;
	localparam logic [31:0] SECS_10_DAYS   = 32'd864000;
	localparam logic [31:0] SECS_PER_HOUR  = 32'd3600;
	localparam logic [31:0] SECS_10_HOURS  = 32'd36000;
	localparam logic [31:0] SECS_PER_MIN   = 32'd60;
	localparam logic [31:0] SECS_10_MINS   = 32'd600;
	localparam logic [31:0] SECS_PER_YEAR  = 32'd31536000;
	localparam logic [31:0] SECS_PER_LEAP  = 32'd31622400;
	localparam logic [31:0] SECS_MONTH_31  = 32'd2678400;
	localparam logic [31:0] SECS_MONTH_30  = 32'd2592000;
	localparam logic [31:0] SECS_MONTH_29  = 32'd2505600;
	localparam logic [31:0] SECS_MONTH_28  = 32'd2419200;

	localparam logic [11:0] EPOCH_YEAR     = 12'd1970;
	localparam logic [11:0] BASE_YEAR      = 12'd2000;
	localparam logic [11:0] NOLEAP_CENTURY = 12'd2100;
	localparam logic [3:0]  LAST_MONTH_IDX = 4'd11;

	localparam logic [31:0] COUNT_RESET    = 32'hFFFF_FFFF;
	localparam logic [5:0]  OFFSET_RESET   = 6'd2;
	localparam logic        REG_OFFSET_IDX = 1'b0;

	localparam logic        KIND_SET       = 1'b0;
	localparam logic        STATUS_OK      = 1'b0;
	localparam logic        STATUS_REJECT  = 1'b1;

	typedef enum logic [4:0] {
		OP_NOP,
		OP_INIT,
		OP_ADD_YEAR,
		OP_ADD_MONTH,
		OP_ADD_DAY,
		OP_ADD_HOUR,
		OP_ADD_MIN,
		OP_STORE,
		OP_LOAD_DEC,
		OP_SUB_YEAR,
		OP_SUB_MONTH,
		OP_SUB_10DAY,
		OP_SUB_DAY,
		OP_SUB_10HR,
		OP_SUB_HR,
		OP_SUB_10MIN,
		OP_SUB_MIN,
		OP_REJECT,
		OP_EMIT
	} op_t;

	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_IS_READ,
		C_BAD,
		C_YR_LT,
		C_MO_LT,
		C_WORK_GE
	} cond_t;

	typedef struct packed {
		op_t              op;
		cond_t            cond;
		logic             gate;
		logic [PC_W-1:0]  target;
	} uword_t;

	typedef struct packed {
		op_t  op;
		logic fire;
	} ctrl_t;

	typedef struct packed {
		logic is_read;
		logic bad;
		logic yr_lt;
		logic mo_lt;
		logic work_ge;
	} flags_t;

	typedef struct packed {
		logic        status;
		logic [31:0] count;
		logic [6:0]  year_offset;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
	} result_t;

	localparam logic [PC_W-1:0] A_START   = 5'd0;
	localparam logic [PC_W-1:0] A_CHECK   = 5'd1;
	localparam logic [PC_W-1:0] A_YEAR    = 5'd2;
	localparam logic [PC_W-1:0] A_MONTH   = 5'd3;
	localparam logic [PC_W-1:0] A_DAY     = 5'd4;
	localparam logic [PC_W-1:0] A_HOUR    = 5'd5;
	localparam logic [PC_W-1:0] A_MIN     = 5'd6;
	localparam logic [PC_W-1:0] A_STORE   = 5'd7;
	localparam logic [PC_W-1:0] A_DEC     = 5'd8;
	localparam logic [PC_W-1:0] A_DYEAR   = 5'd9;
	localparam logic [PC_W-1:0] A_DMONTH  = 5'd10;
	localparam logic [PC_W-1:0] A_D10DAY  = 5'd11;
	localparam logic [PC_W-1:0] A_DDAY    = 5'd12;
	localparam logic [PC_W-1:0] A_D10HR   = 5'd13;
	localparam logic [PC_W-1:0] A_DHR     = 5'd14;
	localparam logic [PC_W-1:0] A_D10MIN  = 5'd15;
	localparam logic [PC_W-1:0] A_DMIN    = 5'd16;
	localparam logic [PC_W-1:0] A_EMIT    = 5'd17;
	localparam logic [PC_W-1:0] A_REJ     = 5'd18;
	localparam logic [PC_W-1:0] A_LAST    = A_REJ;

	// gated word: op runs only while cond holds; self target makes a loop
	function automatic uword_t ucode(input logic [PC_W-1:0] pc);
		uword_t w;
		case (pc)
			A_START:  w = '{OP_INIT,      C_IS_READ, 1'b0, A_DEC};
			A_CHECK:  w = '{OP_NOP,       C_BAD,     1'b0, A_REJ};
			A_YEAR:   w = '{OP_ADD_YEAR,  C_YR_LT,   1'b1, A_YEAR};
			A_MONTH:  w = '{OP_ADD_MONTH, C_MO_LT,   1'b1, A_MONTH};
			A_DAY:    w = '{OP_ADD_DAY,   C_NEVER,   1'b0, A_START};
			A_HOUR:   w = '{OP_ADD_HOUR,  C_NEVER,   1'b0, A_START};
			A_MIN:    w = '{OP_ADD_MIN,   C_NEVER,   1'b0, A_START};
			A_STORE:  w = '{OP_STORE,     C_NEVER,   1'b0, A_START};
			A_DEC:    w = '{OP_LOAD_DEC,  C_NEVER,   1'b0, A_START};
			A_DYEAR:  w = '{OP_SUB_YEAR,  C_WORK_GE, 1'b1, A_DYEAR};
			A_DMONTH: w = '{OP_SUB_MONTH, C_WORK_GE, 1'b1, A_DMONTH};
			A_D10DAY: w = '{OP_SUB_10DAY, C_WORK_GE, 1'b1, A_D10DAY};
			A_DDAY:   w = '{OP_SUB_DAY,   C_WORK_GE, 1'b1, A_DDAY};
			A_D10HR:  w = '{OP_SUB_10HR,  C_WORK_GE, 1'b1, A_D10HR};
			A_DHR:    w = '{OP_SUB_HR,    C_WORK_GE, 1'b1, A_DHR};
			A_D10MIN: w = '{OP_SUB_10MIN, C_WORK_GE, 1'b1, A_D10MIN};
			A_DMIN:   w = '{OP_SUB_MIN,   C_WORK_GE, 1'b1, A_DMIN};
			A_EMIT:   w = '{OP_EMIT,      C_NEVER,   1'b0, A_START};
			A_REJ:    w = '{OP_REJECT,    C_ALWAYS,  1'b0, A_DEC};
			default:  w = '{OP_EMIT,      C_NEVER,   1'b0, A_START};
		endcase
		return w;
	endfunction

	function automatic logic [31:0] month_secs(input logic [3:0] m0, input logic leap);
		logic [31:0] s;
		if (m0 == 4'd1) begin
			s = leap ? SECS_MONTH_29 : SECS_MONTH_28;
		end else if (m0 inside {4'd3, 4'd5, 4'd8, 4'd10}) begin
			s = SECS_MONTH_30;
		end else begin
			s = SECS_MONTH_31;
		end
		return s;
	endfunction

endpackage
`default_nettype wire

### sv/cec_sequencer.sv
// Microcode sequencer: step counter, control store lookup and conditional jumps.
`default_nettype none
module cec_sequencer (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               accept,
	input  cec_pkg::flags_t   flags,
	output cec_pkg::ctrl_t    ctrl,
	output logic              busy
);

	logic [cec_pkg::PC_W-1:0] pc_q;
	logic                     busy_q;
	cec_pkg::uword_t          word;
	logic                     cond_true;

	assign word = cec_pkg::ucode(pc_q);

	always_comb begin
		case (word.cond)
			cec_pkg::C_NEVER:   cond_true = 1'b0;
			cec_pkg::C_ALWAYS:  cond_true = 1'b1;
			cec_pkg::C_IS_READ: cond_true = flags.is_read;
			cec_pkg::C_BAD:     cond_true = flags.bad;
			cec_pkg::C_YR_LT:   cond_true = flags.yr_lt;
			cec_pkg::C_MO_LT:   cond_true = flags.mo_lt;
			cec_pkg::C_WORK_GE: cond_true = flags.work_ge;
			default:            cond_true = 1'b0;
		endcase
	end

	assign ctrl.op   = word.op;
	assign ctrl.fire = busy_q && (!word.gate || cond_true);
	assign busy      = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q   <= cec_pkg::A_START;
		end else if (!busy_q) begin
			if (accept) begin
				busy_q <= 1'b1;
				pc_q   <= cec_pkg::A_START;
			end
		end else if (word.op == cec_pkg::OP_EMIT) begin
			busy_q <= 1'b0;
			pc_q   <= cec_pkg::A_START;
		end else if (cond_true) begin
			pc_q <= word.target;
		end else begin
			pc_q <= pc_q + 5'd1;
		end
	end

	a_pc_in_program: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (pc_q <= cec_pkg::A_LAST))
		else $error("step counter left the program");

endmodule
`default_nettype wire

### sv/cec_datapath.sv
// Datapath: request latch, accumulator, decode remainder, calendar counters, result register.
`default_nettype none
module cec_datapath (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               accept,
	input  wire               kind,
	input  wire  [7:0]        year_offset,
	input  wire  [3:0]        month,
	input  wire  [4:0]        day,
	input  wire  [4:0]        hour,
	input  wire  [5:0]        minute,
	input  wire  [5:0]        second,
	input  wire  [5:0]        offset,
	input  cec_pkg::ctrl_t    ctrl,
	output cec_pkg::flags_t   flags,
	output cec_pkg::result_t  result,
	output logic              done
);

	logic        kind_q;
	logic [7:0]  yo_q;
	logic [3:0]  mo_in_q;
	logic [4:0]  dy_in_q;
	logic [4:0]  hr_in_q;
	logic [5:0]  mi_in_q;
	logic [5:0]  se_in_q;

	logic [31:0] acc_q;
	logic [31:0] cnt_q;
	logic [31:0] work_q;
	logic [11:0] yr_q;
	logic [3:0]  mo_q;
	logic [4:0]  day_q;
	logic [4:0]  hr_q;
	logic [5:0]  mi_q;
	logic        status_q;
	logic        done_q;
	cec_pkg::result_t res_q;

	logic        leap;
	logic [31:0] ylen;
	logic [31:0] msecs;
	logic [31:0] kval;
	logic [31:0] addend;
	logic [31:0] acc_sum;
	logic [31:0] work_dif;
	logic [4:0]  dy_m1;
	logic [11:0] yr_target;
	logic [11:0] yr_rel;
	logic [4:0]  mo_next;

	assign leap  = (yr_q[1:0] == 2'd0) && (yr_q != cec_pkg::NOLEAP_CENTURY);
	assign ylen  = leap ? cec_pkg::SECS_PER_LEAP : cec_pkg::SECS_PER_YEAR;
	assign msecs = cec_pkg::month_secs(mo_q, leap);
	assign dy_m1 = dy_in_q - 5'd1;

	always_comb begin
		case (ctrl.op)
			cec_pkg::OP_SUB_YEAR:  kval = ylen;
			cec_pkg::OP_SUB_MONTH: kval = msecs;
			cec_pkg::OP_SUB_10DAY: kval = cec_pkg::SECS_10_DAYS;
			cec_pkg::OP_SUB_DAY:   kval = cec_pkg::SECS_PER_DAY;
			cec_pkg::OP_SUB_10HR:  kval = cec_pkg::SECS_10_HOURS;
			cec_pkg::OP_SUB_HR:    kval = cec_pkg::SECS_PER_HOUR;
			cec_pkg::OP_SUB_10MIN: kval = cec_pkg::SECS_10_MINS;
			cec_pkg::OP_SUB_MIN:   kval = cec_pkg::SECS_PER_MIN;
			default:               kval = 32'd0;
		endcase
	end

	always_comb begin
		case (ctrl.op)
			cec_pkg::OP_ADD_YEAR:  addend = ylen;
			cec_pkg::OP_ADD_MONTH: addend = msecs;
			cec_pkg::OP_ADD_DAY:   addend = 32'(dy_m1) * cec_pkg::SECS_PER_DAY;
			cec_pkg::OP_ADD_HOUR:  addend = 32'(hr_in_q) * cec_pkg::SECS_PER_HOUR;
			cec_pkg::OP_ADD_MIN:   addend = 32'(mi_in_q) * cec_pkg::SECS_PER_MIN;
			cec_pkg::OP_STORE:     addend = 32'(se_in_q) + 32'(offset);
			default:               addend = 32'd0;
		endcase
	end

	assign acc_sum   = acc_q + addend;
	assign work_dif  = work_q - kval;
	assign yr_target = cec_pkg::BASE_YEAR + 12'(yo_q);
	assign yr_rel    = yr_q - cec_pkg::BASE_YEAR;
	assign mo_next   = 5'(mo_q) + 5'd1;

	assign flags.is_read = (kind_q != cec_pkg::KIND_SET);
	assign flags.bad     = (yo_q > 8'd99) || (mo_in_q == 4'd0) || (mo_in_q > 4'd12) ||
		(dy_in_q == 5'd0) || (hr_in_q > 5'd23) || (mi_in_q > 6'd59) || (se_in_q > 6'd59);
	assign flags.yr_lt   = (yr_q < yr_target);
	assign flags.mo_lt   = (mo_next < 5'(mo_in_q));
	assign flags.work_ge = (work_q >= kval) &&
		!((ctrl.op == cec_pkg::OP_SUB_MONTH) && (mo_q == cec_pkg::LAST_MONTH_IDX));

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q  <= kind;
			yo_q    <= year_offset;
			mo_in_q <= month;
			dy_in_q <= day;
			hr_in_q <= hour;
			mi_in_q <= minute;
			se_in_q <= second;
		end
		if (ctrl.fire) begin
			case (ctrl.op)
				cec_pkg::OP_INIT: begin
					acc_q    <= 32'd0;
					yr_q     <= cec_pkg::EPOCH_YEAR;
					mo_q     <= 4'd0;
					status_q <= cec_pkg::STATUS_OK;
				end
				cec_pkg::OP_ADD_YEAR: begin
					acc_q <= acc_sum;
					yr_q  <= yr_q + 12'd1;
				end
				cec_pkg::OP_ADD_MONTH: begin
					acc_q <= acc_sum;
					mo_q  <= mo_q + 4'd1;
				end
				cec_pkg::OP_ADD_DAY,
				cec_pkg::OP_ADD_HOUR,
				cec_pkg::OP_ADD_MIN: begin
					acc_q <= acc_sum;
				end
				cec_pkg::OP_LOAD_DEC: begin
					work_q <= cnt_q;
					yr_q   <= cec_pkg::EPOCH_YEAR;
					mo_q   <= 4'd0;
					day_q  <= 5'd0;
					hr_q   <= 5'd0;
					mi_q   <= 6'd0;
				end
				cec_pkg::OP_SUB_YEAR: begin
					work_q <= work_dif;
					yr_q   <= yr_q + 12'd1;
				end
				cec_pkg::OP_SUB_MONTH: begin
					work_q <= work_dif;
					mo_q   <= mo_q + 4'd1;
				end
				cec_pkg::OP_SUB_10DAY: begin
					work_q <= work_dif;
					day_q  <= day_q + 5'd10;
				end
				cec_pkg::OP_SUB_DAY: begin
					work_q <= work_dif;
					day_q  <= day_q + 5'd1;
				end
				cec_pkg::OP_SUB_10HR: begin
					work_q <= work_dif;
					hr_q   <= hr_q + 5'd10;
				end
				cec_pkg::OP_SUB_HR: begin
					work_q <= work_dif;
					hr_q   <= hr_q + 5'd1;
				end
				cec_pkg::OP_SUB_10MIN: begin
					work_q <= work_dif;
					mi_q   <= mi_q + 6'd10;
				end
				cec_pkg::OP_SUB_MIN: begin
					work_q <= work_dif;
					mi_q   <= mi_q + 6'd1;
				end
				cec_pkg::OP_REJECT: begin
					status_q <= cec_pkg::STATUS_REJECT;
				end
				cec_pkg::OP_EMIT: begin
					res_q.status      <= status_q;
					res_q.count       <= cnt_q;
					res_q.year_offset <= yr_rel[6:0];
					res_q.month       <= mo_q + 4'd1;
					res_q.day         <= day_q + 5'd1;
					res_q.hour        <= hr_q;
					res_q.minute      <= mi_q;
					res_q.second      <= work_q[5:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= cec_pkg::COUNT_RESET;
			done_q <= 1'b0;
		end else begin
			done_q <= ctrl.fire && (ctrl.op == cec_pkg::OP_EMIT);
			if (ctrl.fire && (ctrl.op == cec_pkg::OP_STORE)) begin
				cnt_q <= acc_sum;
			end
		end
	end

	assign result = res_q;
	assign done   = done_q;

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe held longer than one cycle");

	a_count_by_store: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != $past(cnt_q)) |-> $past(ctrl.fire && (ctrl.op == cec_pkg::OP_STORE)))
		else $error("stored count changed outside a store step");

	a_month_range: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ((res_q.month >= 4'd1) && (res_q.month <= 4'd12)))
		else $error("decoded month out of range");

endmodule
`default_nettype wire

### sv/calendar_epoch_converter_top.sv
// Top level: request handshake, offset register on the APB port, sequencer and datapath.
// A read request decodes the stored count by whole years since 1970, whole months into the year,
// then tens-plus-units day, hour and minute steps; a valid set request first adds years, months,
// day, hour, minute, second and offset into the stored count, then decodes it the same way.
// One request at a time: busy is high from acceptance until the done strobe cycle.
// Reset: stored count all ones, offset 2, sequencer idle. done is never stalled.
`default_nettype none
module calendar_epoch_converter_top (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	output logic        busy,
	input  wire         kind,
	input  wire  [7:0]  year_offset,
	input  wire  [3:0]  month,
	input  wire  [4:0]  day,
	input  wire  [4:0]  hour,
	input  wire  [5:0]  minute,
	input  wire  [5:0]  second,
	output logic        done,
	output logic        status,
	output logic [31:0] stored_count,
	output logic [6:0]  out_year_offset,
	output logic [3:0]  out_month,
	output logic [4:0]  out_day,
	output logic [4:0]  out_hour,
	output logic [5:0]  out_minute,
	output logic [5:0]  out_second,
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [2:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic              accept;
	logic [5:0]        offset_q;
	logic              seq_busy;
	cec_pkg::ctrl_t    ctrl;
	cec_pkg::flags_t   flags;
	cec_pkg::result_t  result;

	assign accept = start && !seq_busy;
	assign busy   = seq_busy;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= cec_pkg::OFFSET_RESET;
		end else if (psel && penable && pwrite && pready &&
			(paddr[2] == cec_pkg::REG_OFFSET_IDX)) begin
			offset_q <= pwdata[5:0];
		end
	end

	assign prdata = (paddr[2] == cec_pkg::REG_OFFSET_IDX) ? {26'd0, offset_q} : 32'd0;

	cec_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.flags  (flags),
		.ctrl   (ctrl),
		.busy   (seq_busy)
	);

	cec_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.kind        (kind),
		.year_offset (year_offset),
		.month       (month),
		.day         (day),
		.hour        (hour),
		.minute      (minute),
		.second      (second),
		.offset      (offset_q),
		.ctrl        (ctrl),
		.flags       (flags),
		.result      (result),
		.done        (done)
	);

	assign status          = result.status;
	assign stored_count    = result.count;
	assign out_year_offset = result.year_offset;
	assign out_month       = result.month;
	assign out_day         = result.day;
	assign out_hour        = result.hour;
	assign out_minute      = result.minute;
	assign out_second      = result.second;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("request accepted but sequencer not busy");

endmodule
`default_nettype wire

### tb/sv/calendar_epoch_converter_top_tb.sv
// Testbench for calendar_epoch_converter_top: directed and random set/read requests.
`timescale 1ns / 1ps
module calendar_epoch_converter_top_tb;

	localparam logic       KIND_READ   = ~cec_pkg::KIND_SET;
	localparam logic [2:0] OFFSET_ADDR = {cec_pkg::REG_OFFSET_IDX, 2'b00};

	typedef struct packed {
		logic       kind;
		logic [7:0] year_offset;
		logic [3:0] month;
		logic [4:0] day;
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
	} cal_request_t;

	class epoch_tracker;
		logic [31:0]      held_count;
		logic [5:0]       offset_secs;
		cec_pkg::result_t pending_results[$];
		int               mismatches;

		function new();
			held_count  = cec_pkg::COUNT_RESET;
			offset_secs = cec_pkg::OFFSET_RESET;
			mismatches  = 0;
		endfunction

		function bit is_leap(int unsigned y);
			return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
		endfunction

		function int unsigned month_length_days(int unsigned y, int unsigned m0);
			int unsigned d;
			case (m0)
				1: begin
					d = is_leap(y) ? 29 : 28;
				end
				3, 5, 8, 10: begin
					d = 30;
				end
				default: begin
					d = 31;
				end
			endcase
			return d;
		endfunction

		function logic [31:0] calendar_to_seconds(cal_request_t q);
			logic [31:0] acc;
			int unsigned y;
			int unsigned m0;
			acc = '0;
			for (y = 1970; y < 2000 + q.year_offset; y++) begin
				acc += is_leap(y) ? cec_pkg::SECS_PER_LEAP : cec_pkg::SECS_PER_YEAR;
			end
			for (m0 = 0; m0 + 1 < q.month; m0++) begin
				acc += 32'(month_length_days(2000 + q.year_offset, m0)) * cec_pkg::SECS_PER_DAY;
			end
			acc += 32'(q.day - 1) * cec_pkg::SECS_PER_DAY;
			acc += 32'(q.hour) * cec_pkg::SECS_PER_HOUR;
			acc += 32'(q.minute) * cec_pkg::SECS_PER_MIN;
			acc += 32'(q.second);
			return acc;
		endfunction

		function cec_pkg::result_t breakdown(logic [31:0] cnt);
			cec_pkg::result_t r;
			int unsigned      days;
			int unsigned      rem;
			int unsigned      y;
			int unsigned      m0;
			days = cnt / cec_pkg::SECS_PER_DAY;
			rem  = cnt % cec_pkg::SECS_PER_DAY;
			y    = 1970;
			m0   = 0;
			while (days >= (is_leap(y) ? 366 : 365)) begin
				days -= is_leap(y) ? 366 : 365;
				y++;
			end
			while (m0 < 11 && days >= month_length_days(y, m0)) begin
				days -= month_length_days(y, m0);
				m0++;
			end
			r.status      = cec_pkg::STATUS_OK;
			r.count       = cnt;
			r.year_offset = 7'(y - 2000);
			r.month       = 4'(m0 + 1);
			r.day         = 5'(days + 1);
			r.hour        = 5'(rem / 3600);
			r.minute      = 6'((rem % 3600) / 60);
			r.second      = 6'(rem % 60);
			return r;
		endfunction

		function void note_request(cal_request_t q);
			cec_pkg::result_t r;
			logic             bad;
			bad = 1'b0;
			if (q.kind == cec_pkg::KIND_SET) begin
				bad = q.year_offset > 99 || q.month < 1 || q.month > 12 || q.day == 0 ||
					q.hour > 23 || q.minute > 59 || q.second > 59;
				if (!bad) begin
					held_count = calendar_to_seconds(q) + 32'(offset_secs);
				end
			end
			r = breakdown(held_count);
			r.status = bad ? cec_pkg::STATUS_REJECT : cec_pkg::STATUS_OK;
			pending_results.push_back(r);
		endfunction

		function void field_check(string name, longint unsigned e, longint unsigned a);
			if (e != a) begin
				mismatches++;
				$display("%0t: %s mismatch expected %0d actual %0d", $time, name, e, a);
			end
		endfunction

		function void check_result(cec_pkg::result_t act);
			cec_pkg::result_t e;
			if (pending_results.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result expected none actual count %0d",
					$time, act.count);
				return;
			end
			e = pending_results.pop_front();
			field_check("status", e.status, act.status);
			field_check("stored_count", e.count, act.count);
			field_check("out_year_offset", e.year_offset, act.year_offset);
			field_check("out_month", e.month, act.month);
			field_check("out_day", e.day, act.day);
			field_check("out_hour", e.hour, act.hour);
			field_check("out_minute", e.minute, act.minute);
			field_check("out_second", e.second, act.second);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        kind;
	logic [7:0]  year_offset;
	logic [3:0]  month;
	logic [4:0]  day;
	logic [4:0]  hour;
	logic [5:0]  minute;
	logic [5:0]  second;
	logic        done;
	logic        status;
	logic [31:0] stored_count;
	logic [6:0]  out_year_offset;
	logic [3:0]  out_month;
	logic [4:0]  out_day;
	logic [4:0]  out_hour;
	logic [5:0]  out_minute;
	logic [5:0]  out_second;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	epoch_tracker tracker = new();
	bit           burst;

	calendar_epoch_converter_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.kind(kind),
		.year_offset(year_offset),
		.month(month),
		.day(day),
		.hour(hour),
		.minute(minute),
		.second(second),
		.done(done),
		.status(status),
		.stored_count(stored_count),
		.out_year_offset(out_year_offset),
		.out_month(out_month),
		.out_day(out_day),
		.out_hour(out_hour),
		.out_minute(out_minute),
		.out_second(out_second),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && done) begin
			tracker.check_result('{status, stored_count, out_year_offset, out_month,
				out_day, out_hour, out_minute, out_second});
		end
	end

	function automatic cal_request_t make_req(logic k, logic [7:0] yo, logic [3:0] mo,
		logic [4:0] dy, logic [4:0] hr, logic [5:0] mi, logic [5:0] se);
		cal_request_t q;
		q = '{k, yo, mo, dy, hr, mi, se};
		return q;
	endfunction

	function automatic cal_request_t random_request();
		cal_request_t q;
		int unsigned  pick;
		pick = $urandom_range(0, 9);
		q = make_req(cec_pkg::KIND_SET, 8'($urandom_range(0, 99)), 4'($urandom_range(1, 12)),
			5'($urandom_range(1, 31)), 5'($urandom_range(0, 23)),
			6'($urandom_range(0, 59)), 6'($urandom_range(0, 59)));
		if (pick >= 6 && pick <= 8) begin
			q = make_req(cec_pkg::KIND_SET, 8'($urandom()), 4'($urandom()), 5'($urandom()),
				5'($urandom()), 6'($urandom()), 6'($urandom()));
			if (pick != 8) begin
				q.kind = KIND_READ;
			end
		end else if (pick == 9) begin
			case ($urandom_range(0, 5))
				0: q.year_offset = 8'($urandom_range(100, 255));
				1: q.month = ($urandom_range(0, 3) == 0) ? 4'd0 : 4'($urandom_range(13, 15));
				2: q.day = 5'd0;
				3: q.hour = 5'($urandom_range(24, 31));
				4: q.minute = 6'($urandom_range(60, 63));
				default: q.second = 6'($urandom_range(60, 63));
			endcase
		end
		return q;
	endfunction

	task automatic send_request(cal_request_t q, int unsigned gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start       <= 1'b1;
		kind        <= q.kind;
		year_offset <= q.year_offset;
		month       <= q.month;
		day         <= q.day;
		hour        <= q.hour;
		minute      <= q.minute;
		second      <= q.second;
		do @(posedge clk); while (busy);
		tracker.note_request(q);
	endtask

	task automatic send_set(logic [7:0] yo, logic [3:0] mo, logic [4:0] dy,
		logic [4:0] hr, logic [5:0] mi, logic [5:0] se);
		send_request(make_req(cec_pkg::KIND_SET, yo, mo, dy, hr, mi, se),
			$urandom_range(0, 17));
	endtask

	task automatic drain();
		start <= 1'b0;
		while (tracker.pending_results.size() != 0 || busy) @(posedge clk);
	endtask

	task automatic write_offset(logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= OFFSET_ADDR;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		tracker.offset_secs = data[5:0];
	endtask

	initial begin
		#20_000_000;
		$display("calendar_epoch_converter_top_tb NOT OK");
		$finish;
	end

	initial begin
		arst_n      <= 1'b0;
		start       <= 1'b0;
		kind        <= cec_pkg::KIND_SET;
		year_offset <= '0;
		month       <= '0;
		day         <= '0;
		hour        <= '0;
		minute      <= '0;
		second      <= '0;
		psel        <= 1'b0;
		penable     <= 1'b0;
		pwrite      <= 1'b0;
		paddr       <= '0;
		pwdata      <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset count decodes past 2100
		send_request(make_req(KIND_READ, '0, '0, '0, '0, '0, '0), 0);
		send_set(8'd0, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0);
		send_set(8'd99, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59);
		send_set(8'd0, 4'd2, 5'd29, 5'd12, 6'd30, 6'd30);
		send_set(8'd0, 4'd12, 5'd31, 5'd0, 6'd0, 6'd0);
		send_set(8'd1, 4'd2, 5'd31, 5'd0, 6'd0, 6'd0);
		send_set(8'd100, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0);
		send_set(8'd255, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63);
		send_set(8'd5, 4'd0, 5'd1, 5'd0, 6'd0, 6'd0);
		send_set(8'd5, 4'd13, 5'd1, 5'd0, 6'd0, 6'd0);
		send_set(8'd5, 4'd3, 5'd0, 5'd0, 6'd0, 6'd0);
		send_set(8'd5, 4'd3, 5'd1, 5'd24, 6'd0, 6'd0);
		send_set(8'd5, 4'd3, 5'd1, 5'd0, 6'd60, 6'd0);
		send_set(8'd5, 4'd3, 5'd1, 5'd0, 6'd0, 6'd60);
		send_request(make_req(KIND_READ, 8'hFF, 4'hF, 5'h1F, 5'h1F, 6'h3F, 6'h3F), 0);
		drain();
		write_offset(32'd63);
		// max offset pushes the last valid second into 2100
		send_set(8'd99, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59);
		send_request(make_req(KIND_READ, '0, '0, '0, '0, '0, '0), 3);
		drain();
		write_offset(32'd0);
		send_set(8'd0, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0);
		send_set(8'd50, 4'd6, 5'd15, 5'd9, 6'd41, 6'd7);
		send_set(8'd4, 4'd2, 5'd29, 5'd23, 6'd59, 6'd59);

		for (int phase = 0; phase < 4; phase++) begin
			drain();
			case (phase)
				1: write_offset(32'd63);
				2: write_offset(32'd0);
				default: write_offset($urandom());
			endcase
			for (int n = 0; n < 100; n++) begin
				if (n % 25 == 0) begin
					burst = ($urandom_range(0, 2) == 0);
				end
				send_request(random_request(), burst ? 0 : $urandom_range(0, 17));
			end
		end

		drain();
		repeat (400) @(posedge clk);
		if (tracker.mismatches == 0) begin
			$display("calendar_epoch_converter_top_tb OK");
		end else begin
			$display("calendar_epoch_converter_top_tb NOT OK");
		end
		$finish;
	end

endmodule

### files.f
sv/cec_pkg.sv
sv/cec_sequencer.sv
sv/cec_datapath.sv
sv/calendar_epoch_converter_top.sv
tb/sv/calendar_epoch_converter_top_tb.sv
